FILE: sv/sst_pkg.sv
package sst_pkg;

   localparam int POS_W = 16;
   localparam int LINE_W = 16;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_IDX_W = $clog2(KW_MAX_LEN);
   localparam int MAX_BURST = 3;
   localparam int BURST_W = $clog2(MAX_BURST + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   localparam logic [3:0] M_IDLE     = 4'd0;
   localparam logic [3:0] M_SLASH    = 4'd1;
   localparam logic [3:0] M_COMMENT  = 4'd2;
   localparam logic [3:0] M_BANG     = 4'd3;
   localparam logic [3:0] M_EQUAL    = 4'd4;
   localparam logic [3:0] M_LESS     = 4'd5;
   localparam logic [3:0] M_GREATER  = 4'd6;
   localparam logic [3:0] M_STRING   = 4'd7;
   localparam logic [3:0] M_NUMBER   = 4'd8;
   localparam logic [3:0] M_NUMDOT   = 4'd9;
   localparam logic [3:0] M_FRACTION = 4'd10;
   localparam logic [3:0] M_IDENT    = 4'd11;

   localparam logic [5:0] K_LPAREN    = 6'd0;
   localparam logic [5:0] K_RPAREN    = 6'd1;
   localparam logic [5:0] K_LBRACE    = 6'd2;
   localparam logic [5:0] K_RBRACE    = 6'd3;
   localparam logic [5:0] K_COMMA     = 6'd4;
   localparam logic [5:0] K_DOT       = 6'd5;
   localparam logic [5:0] K_MINUS     = 6'd6;
   localparam logic [5:0] K_PLUS      = 6'd7;
   localparam logic [5:0] K_SEMICOLON = 6'd8;
   localparam logic [5:0] K_SLASH     = 6'd9;
   localparam logic [5:0] K_STAR      = 6'd10;
   localparam logic [5:0] K_BANG      = 6'd11;
   localparam logic [5:0] K_EQUAL     = 6'd13;
   localparam logic [5:0] K_GREATER   = 6'd15;
   localparam logic [5:0] K_LESS      = 6'd17;
   localparam logic [5:0] K_IDENT     = 6'd19;
   localparam logic [5:0] K_STRING    = 6'd20;
   localparam logic [5:0] K_NUMBER    = 6'd21;
   localparam logic [5:0] K_AND       = 6'd22;
   localparam logic [5:0] K_CLASS     = 6'd23;
   localparam logic [5:0] K_ELSE      = 6'd24;
   localparam logic [5:0] K_FALSE     = 6'd25;
   localparam logic [5:0] K_FOR       = 6'd26;
   localparam logic [5:0] K_FUN       = 6'd27;
   localparam logic [5:0] K_IF        = 6'd28;
   localparam logic [5:0] K_NIL       = 6'd29;
   localparam logic [5:0] K_OR        = 6'd30;
   localparam logic [5:0] K_PRINT     = 6'd31;
   localparam logic [5:0] K_RETURN    = 6'd32;
   localparam logic [5:0] K_SUPER     = 6'd33;
   localparam logic [5:0] K_THIS      = 6'd34;
   localparam logic [5:0] K_TRUE      = 6'd35;
   localparam logic [5:0] K_VAR       = 6'd36;
   localparam logic [5:0] K_WHILE     = 6'd37;
   localparam logic [5:0] K_ERR_CHAR  = 6'd38;
   localparam logic [5:0] K_ERR_STR   = 6'd39;
   localparam logic [5:0] K_END       = 6'd40;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_QMARK   = 8'h3F;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   typedef logic [KW_MAX_LEN-1:0][7:0] kw_buf_type;

   typedef struct packed {
      logic [5:0]        kind;
      logic [15:0]       start;
      logic [15:0]       length;
      logic [LINE_W-1:0] line;
      logic              last;
   } token_type;

   typedef struct packed {
      logic [BURST_W-1:0]               count;
      token_type [MAX_BURST-1:0]        tok;
   } burst_type;

   function automatic logic decimal_char(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic ident_char(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CH_UNDER) || (c == CH_QMARK);
   endfunction

   function automatic token_type make_token(logic [5:0] kind, logic [POS_W-1:0] start,
                                            logic [POS_W:0] stop, logic [LINE_W-1:0] line);
      token_type  t;
      logic [POS_W:0] len;
      len = (stop >= {1'b0, start}) ? stop - {1'b0, start} : '0;
      t.kind   = kind;
      t.start  = start;
      t.length = len[POS_W] ? 16'hFFFF : len[15:0];
      t.line   = line;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic logic [5:0] keyword_kind(kw_buf_type b, logic [KW_IDX_W-1:0] len);
      logic [5:0] k;
      k = K_IDENT;
      case (len)
         3'd2: begin
            if ({b[0], b[1]} == "if") k = K_IF;
            else if ({b[0], b[1]} == "or") k = K_OR;
         end
         3'd3: begin
            if ({b[0], b[1], b[2]} == "and") k = K_AND;
            else if ({b[0], b[1], b[2]} == "for") k = K_FOR;
            else if ({b[0], b[1], b[2]} == "fun") k = K_FUN;
            else if ({b[0], b[1], b[2]} == "nil") k = K_NIL;
            else if ({b[0], b[1], b[2]} == "var") k = K_VAR;
         end
         3'd4: begin
            if ({b[0], b[1], b[2], b[3]} == "else") k = K_ELSE;
            else if ({b[0], b[1], b[2], b[3]} == "this") k = K_THIS;
            else if ({b[0], b[1], b[2], b[3]} == "true") k = K_TRUE;
         end
         3'd5: begin
            if ({b[0], b[1], b[2], b[3], b[4]} == "class") k = K_CLASS;
            else if ({b[0], b[1], b[2], b[3], b[4]} == "false") k = K_FALSE;
            else if ({b[0], b[1], b[2], b[3], b[4]} == "print") k = K_PRINT;
            else if ({b[0], b[1], b[2], b[3], b[4]} == "super") k = K_SUPER;
            else if ({b[0], b[1], b[2], b[3], b[4]} == "while") k = K_WHILE;
         end
         3'd6: begin
            if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "return") k = K_RETURN;
         end
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage

FILE: sv/script_source_tokenizer_unit.sv
// A token is written into the registered token queue when the byte that closes it is accepted.
// Throughput: one source byte per cycle while the token queue holds at most one token,
// or two with one leaving; a byte that closes two or three tokens queues them all at once.
// The queue is four tokens deep, set by the worst case of three tokens from one byte.
// Reset is synchronous and active high: scanner idle, offsets zero, line one, queue empty.
module script_source_tokenizer_unit
   import sst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_token_line,
   output logic        rsp_last_of_run
);

   logic      accept;
   burst_type burst;
   token_type head;

   assign accept = req_valid && req_ready;

   sst_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .burst       (burst)
   );

   sst_token_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .burst      (burst),
      .space_ok   (req_ready),
      .head_valid (rsp_valid),
      .pop        (rsp_ready),
      .head       (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_token_line   = head.line;
   assign rsp_last_of_run  = head.last;

endmodule

FILE: sv/sst_scan_core.sv
module sst_scan_core
   import sst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] source_byte,
   output burst_type  burst
);

   logic [3:0]        mode_ff, mode_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LINE_W-1:0] line_ff, line_in;
   kw_buf_type        kw_ff;

   logic                kw_wr;
   logic [KW_IDX_W-1:0] kw_idx;

   always_comb begin
      logic [7:0]          c;
      logic [POS_W-1:0]    cur;
      logic [POS_W:0]      cur1;
      logic [POS_W-1:0]    diff;
      logic [POS_W-1:0]    dot;
      logic [5:0]          base;
      logic                do_idle;
      logic                line_inc;
      logic [1:0]          n;
      token_type [MAX_BURST-1:0] toks;
      logic                idle_emit;
      token_type           idle_tok;
      logic [5:0]          single;

      c        = source_byte;
      cur      = pos_ff;
      cur1     = {1'b0, cur} + 1'b1;
      diff     = (cur >= start_ff) ? cur - start_ff : '0;
      dot      = (cur != '0) ? cur - 1'b1 : '0;
      mode_in  = mode_ff;
      start_in = start_ff;
      do_idle  = 1'b0;
      line_inc = 1'b0;
      n        = '0;
      toks     = '0;
      kw_wr    = 1'b0;
      kw_idx   = '0;
      base     = K_BANG;
      idle_emit = 1'b0;
      idle_tok  = '0;
      single    = K_ERR_CHAR;

      case (mode_ff)
         M_SLASH: begin
            if (c == CH_SLASH) begin
               mode_in = M_COMMENT;
            end else begin
               toks[0] = make_token(K_SLASH, start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         M_COMMENT: begin
            if ((c == CH_LF) || (c == CH_NUL)) do_idle = 1'b1;
         end
         M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
            base = (mode_ff == M_BANG) ? K_BANG : (mode_ff == M_EQUAL) ? K_EQUAL :
                   (mode_ff == M_LESS) ? K_LESS : K_GREATER;
            if (c == CH_EQUAL) begin
               toks[0] = make_token(base + 6'd1, start_ff, cur1, line_ff);
               n = 2'd1;
               mode_in = M_IDLE;
            end else begin
               toks[0] = make_token(base, start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         M_STRING: begin
            if (c == CH_QUOTE) begin
               toks[0] = make_token(K_STRING, start_ff, cur1, line_ff);
               n = 2'd1;
               mode_in = M_IDLE;
            end else if (c == CH_LF) begin
               line_inc = 1'b1;
            end else if (c == CH_NUL) begin
               toks[0] = make_token(K_ERR_STR, start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         M_NUMBER: begin
            if (decimal_char(c)) begin
               mode_in = M_NUMBER;
            end else if (c == CH_DOT) begin
               mode_in = M_NUMDOT;
            end else begin
               toks[0] = make_token(K_NUMBER, start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         M_NUMDOT: begin
            if (decimal_char(c)) begin
               mode_in = M_FRACTION;
            end else begin
               toks[0] = make_token(K_NUMBER, start_ff, {1'b0, dot}, line_ff);
               toks[1] = make_token(K_DOT, dot, {1'b0, cur}, line_ff);
               n = 2'd2;
               do_idle = 1'b1;
            end
         end
         M_FRACTION: begin
            if (!decimal_char(c)) begin
               toks[0] = make_token(K_NUMBER, start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         M_IDENT: begin
            if (ident_char(c) || decimal_char(c)) begin
               kw_wr  = (diff < POS_W'(KW_MAX_LEN));
               kw_idx = diff[KW_IDX_W-1:0];
            end else begin
               toks[0] = make_token(((diff == '0) || (diff > POS_W'(KW_MAX_LEN))) ? K_IDENT :
                                    keyword_kind(kw_ff, diff[KW_IDX_W-1:0]),
                                    start_ff, {1'b0, cur}, line_ff);
               n = 2'd1;
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         mode_in  = M_IDLE;
         start_in = cur;
         case (c)
            CH_SPACE, CH_CR, CH_TAB: idle_emit = 1'b0;
            CH_LF:      line_inc = 1'b1;
            CH_NUL: begin
               idle_emit = 1'b1;
               idle_tok  = make_token(K_END, cur, {1'b0, cur}, line_ff);
            end
            CH_LPAREN:  single = K_LPAREN;
            CH_RPAREN:  single = K_RPAREN;
            CH_LBRACE:  single = K_LBRACE;
            CH_RBRACE:  single = K_RBRACE;
            CH_COMMA:   single = K_COMMA;
            CH_DOT:     single = K_DOT;
            CH_MINUS:   single = K_MINUS;
            CH_PLUS:    single = K_PLUS;
            CH_SEMI:    single = K_SEMICOLON;
            CH_STAR:    single = K_STAR;
            CH_SLASH:   mode_in = M_SLASH;
            CH_BANG:    mode_in = M_BANG;
            CH_EQUAL:   mode_in = M_EQUAL;
            CH_LESS:    mode_in = M_LESS;
            CH_GREATER: mode_in = M_GREATER;
            CH_QUOTE:   mode_in = M_STRING;
            default: begin
               if (ident_char(c)) begin
                  mode_in = M_IDENT;
                  kw_wr   = 1'b1;
                  kw_idx  = '0;
               end else if (decimal_char(c)) begin
                  mode_in = M_NUMBER;
               end else begin
                  idle_emit = 1'b1;
                  idle_tok  = make_token(K_ERR_CHAR, cur, cur1, line_ff);
               end
            end
         endcase
         if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
             (c == CH_COMMA) || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS) ||
             (c == CH_SEMI) || (c == CH_STAR)) begin
            idle_emit = 1'b1;
            idle_tok  = make_token(single, cur, cur1, line_ff);
         end
         if (idle_emit) begin
            toks[n] = idle_tok;
            n = n + 2'd1;
         end
      end

      for (int i = 0; i < MAX_BURST; i++) begin
         toks[i].last = (BURST_W'(n) == BURST_W'(i + 1));
      end
      burst.count = BURST_W'(n);
      burst.tok   = toks;

      line_in = (line_inc && (line_ff != LINE_MAX)) ? line_ff + 1'b1 : line_ff;
      pos_in  = (cur != POS_MAX) ? cur + 1'b1 : cur;
      if (c == CH_NUL) begin
         mode_in  = M_IDLE;
         start_in = '0;
         pos_in   = '0;
         line_in  = LINE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= LINE_W'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && kw_wr) begin
         kw_ff[kw_idx] <= source_byte;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (accept && (source_byte == CH_NUL)) |=>
         ((mode_ff == M_IDLE) && (pos_ff == '0) && (line_ff == LINE_W'(1))))
      else $error("end of source did not restart the scanner");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (source_byte == CH_NUL)) |-> (burst.count != '0))
      else $error("end of source produced no end token");
`endif

endmodule

FILE: sv/sst_token_fifo.sv
module sst_token_fifo
   import sst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type burst,
   output logic      space_ok,
   output logic      head_valid,
   input  logic      pop,
   output token_type head
);

   token_type [FIFO_DEPTH-1:0] mem_ff;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             take;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign take       = pop && head_valid;
   assign space_ok   = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_BURST) + CNT_W'(take));

   always_comb begin
      rd_in    = take ? rd_ff + 1'b1 : rd_ff;
      wr_in    = push ? wr_ff + PTR_W'(burst.count) : wr_ff;
      count_in = count_ff + (push ? CNT_W'(burst.count) : '0) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BURST; i++) begin
         if (push && (BURST_W'(i) < burst.count)) begin
            mem_ff[wr_ff + PTR_W'(i)] <= burst.tok[i];
         end
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("token queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> ((CNT_W + 1)'(count_ff) + (CNT_W + 1)'(burst.count) <=
                (CNT_W + 1)'(FIFO_DEPTH) + (CNT_W + 1)'(take)))
      else $error("token queue overflow");
`endif

endmodule
